// ===== rtl/core/text_console_writer_macros.svh =====
// Assertion macros shared by the console writer's checker.
// No dependencies; include by bare file name where assertions are written.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Check prop at every rising edge of clk, skip while rst is high.
`define TCW_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at every rising edge of clk, reset cycles included.
`define TCW_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
// Shared constants for the text console writer: operation codes, control
// characters, register map and default screen geometry. No dependencies.
package tcw_pkg;

   // Operation codes of an input beat
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   // Control characters and the blank glyph
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_BLANK     = 8'h20;
   localparam int         TAB_STOP     = 8;

   // Attribute after reset and the cell every position holds after reset
   localparam logic [7:0]  RESET_COLOR = 8'h07;
   localparam logic [15:0] RESET_BLANK = {RESET_COLOR, CH_BLANK};

   // Register map: one register, index taken from byte address bit 2
   localparam int   CSR_ADDR_W     = 3;
   localparam logic REG_TEXT_COLOR = 1'b0;

   // Default geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

endpackage

// ===== rtl/core/tcw_cell_ram.sv =====
// Screen cell memory: one write port and one read port, read data registered.
// No package dependencies.
module tcw_cell_ram #(
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = 11,
   parameter int DATA_W = 16
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] cells [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= cells[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/text_console_writer.sv =====
// Text console writer top level: screen memory sequencer, write position,
// result register and register port. Depends on tcw_pkg and tcw_cell_ram.
//
// A text-mode screen of ROWS x COLUMNS 16-bit cells (glyph in the low byte,
// attribute in the high byte) kept in one single-port-write, single-port-read
// memory with registered read data. Each input beat is a put (printable
// character, backspace, newline or tab), a cell read or a screen clear; each
// gives exactly one result beat with the displayed cursor, plus the cell for
// a read. An ordinary put, a read or an unused operation is accepted, then
// the result register is loaded. A put that runs past the last row scrolls
// the screen, and a clear blanks it: both sweep the memory one cell a
// cycle, the scroll copying each cell above the last row from one row below
// through the read port into the write port and blanking the last row.
// After reset the block runs a clearing pass over all ROWS*COLUMNS cells
// (2000 at 80x25) that fills every cell with 0x0720; req_stall stays high
// meanwhile, register writes are taken as usual. text_color may be written
// any time the block is idle. The result register lets the next beat be
// accepted while a result still waits on rsp_stall.
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_operation,
   input  logic [7:0]            req_char_code,
   input  logic [4:0]            req_cell_row,
   input  logic [6:0]            req_cell_column,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [4:0]            rsp_cursor_row,
   output logic [6:0]            rsp_cursor_column,
   output logic [15:0]           rsp_read_data,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   localparam int CELLS    = ROWS * COLUMNS;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int ROW_W    = $clog2(ROWS);
   localparam int COL_W    = $clog2(COLUMNS);
   localparam int COPY_END = CELLS - COLUMNS;

   // Sequencer states
   localparam logic [1:0] ST_SWEEP = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RESP  = 2'd2;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] scan_ff, scan_in;           // sweep position
   logic              copy_ff, copy_in;           // sweep scrolls (else fills)
   logic              resp_pend_ff, resp_pend_in; // sweep ends in a result
   logic [15:0]       fill_ff, fill_in;           // blank written by a sweep

   // Write-back stage: every memory write goes through it, one a cycle
   logic              wb_valid_ff, wb_valid_in;
   logic              wb_copy_ff, wb_copy_in;     // take data from read port
   logic [ADDR_W-1:0] wb_addr_ff, wb_addr_in;
   logic [15:0]       wb_data_ff, wb_data_in;

   logic [ROW_W-1:0]  row_ff, row_in;             // write position
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  shown_row_ff, shown_row_in; // displayed cursor
   logic [COL_W-1:0]  shown_col_ff, shown_col_in;
   logic              read_ok_ff, read_ok_in;     // read beat hit the screen

   logic [7:0]        text_color_ff;

   logic              rsp_valid_ff;
   logic [4:0]        rsp_row_ff;
   logic [6:0]        rsp_col_ff;
   logic [15:0]       rsp_data_ff;

   // ---------------------------------------------------------------------
   // Memory
   // ---------------------------------------------------------------------
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;
   logic [15:0]       wr_data;

   assign wr_data = wb_copy_ff ? rd_data : wb_data_ff;

   tcw_cell_ram #(
      .DEPTH  (CELLS),
      .ADDR_W (ADDR_W),
      .DATA_W (16)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (wb_valid_ff),
      .wr_addr (wb_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------------------------------------------------------------
   // Handshakes. Hold off a new beat while a write-back is still pending,
   // so a read never races the write of the same cell.
   // ---------------------------------------------------------------------
   logic req_accept;
   logic rsp_load;
   logic [15:0] blank_cell;

   assign req_stall  = (state_ff != ST_IDLE) || wb_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign blank_cell = {text_color_ff, CH_BLANK};

   // ---------------------------------------------------------------------
   // Read beat address
   // ---------------------------------------------------------------------
   logic              read_hit;
   logic [ADDR_W-1:0] cell_addr;

   assign read_hit  = (int'(req_cell_row) < ROWS) && (int'(req_cell_column) < COLUMNS);
   assign cell_addr = ADDR_W'(int'(req_cell_row) * COLUMNS + int'(req_cell_column));

   // ---------------------------------------------------------------------
   // Put: next write position and the cell it writes
   // ---------------------------------------------------------------------
   logic [ROW_W-1:0]  put_row;
   logic [COL_W-1:0]  put_col;
   logic              put_we;
   logic              put_scroll;
   logic [COL_W:0]    tab_col;
   logic [COL_W:0]    inc_col;
   logic              new_line;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] bs_addr;

   assign tab_col = {1'b0, col_ff | COL_W'(TAB_STOP - 1)} + (COL_W + 1)'(1);
   assign inc_col = {1'b0, col_ff} + (COL_W + 1)'(1);

   always_comb begin
      put_row    = row_ff;
      put_col    = col_ff;
      put_we     = 1'b0;
      put_scroll = 1'b0;
      new_line   = 1'b0;
      case (req_char_code)
         CH_BACKSPACE: begin
            // step back, wrap to the end of the previous line, stop at 0,0
            if (col_ff != '0) begin
               put_col = col_ff - COL_W'(1);
            end else if (row_ff != '0) begin
               put_row = row_ff - ROW_W'(1);
               put_col = COL_W'(COLUMNS - 1);
            end
            put_we = 1'b1;
         end
         CH_NEWLINE: begin
            new_line = 1'b1;
         end
         CH_TAB: begin
            if (int'(tab_col) >= COLUMNS) begin
               new_line = 1'b1;
            end else begin
               put_col = tab_col[COL_W-1:0];
            end
         end
         default: begin
            put_we = 1'b1;
            if (int'(inc_col) >= COLUMNS) begin
               new_line = 1'b1;
            end else begin
               put_col = inc_col[COL_W-1:0];
            end
         end
      endcase
      if (new_line) begin
         put_col = '0;
         if (int'(row_ff) == ROWS - 1) begin
            put_scroll = 1'b1;
         end else begin
            put_row = row_ff + ROW_W'(1);
         end
      end
   end

   // printable goes at the old position, backspace blanks the new one
   assign cur_addr = ADDR_W'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign bs_addr  = ADDR_W'(int'(put_row) * COLUMNS + int'(put_col));

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      copy_in      = copy_ff;
      resp_pend_in = resp_pend_ff;
      fill_in      = fill_ff;
      wb_valid_in  = 1'b0;
      wb_copy_in   = 1'b0;
      wb_addr_in   = wb_addr_ff;
      wb_data_in   = wb_data_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      shown_row_in = shown_row_ff;
      shown_col_in = shown_col_ff;
      read_ok_in   = read_ok_ff;
      rd_en        = 1'b0;
      rd_addr      = cell_addr;
      rsp_load     = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            // Scroll: read the cell one row below, write it back here next
            // cycle. Reads run a row ahead of writes, so no cell is
            // overwritten before it is copied. Past the copy range, fill.
            wb_valid_in = 1'b1;
            wb_addr_in  = scan_ff;
            if (copy_ff && (int'(scan_ff) < COPY_END)) begin
               rd_en      = 1'b1;
               rd_addr    = ADDR_W'(int'(scan_ff) + COLUMNS);
               wb_copy_in = 1'b1;
            end else begin
               wb_data_in = fill_ff;
            end
            if (scan_ff == ADDR_W'(CELLS - 1)) begin
               scan_in  = '0;
               state_in = resp_pend_ff ? ST_RESP : ST_IDLE;
            end else begin
               scan_in = scan_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               resp_pend_in = 1'b1;
               read_ok_in   = 1'b0;
               state_in     = ST_RESP;
               case (req_operation)
                  OP_PUT: begin
                     row_in       = put_row;
                     col_in       = put_col;
                     shown_row_in = put_row;
                     shown_col_in = put_col;
                     wb_valid_in  = put_we;
                     wb_addr_in   = (req_char_code == CH_BACKSPACE) ? bs_addr : cur_addr;
                     wb_data_in   = (req_char_code == CH_BACKSPACE) ? blank_cell
                                                                    : {text_color_ff,
                                                                       req_char_code};
                     copy_in      = 1'b1;
                     fill_in      = blank_cell;
                     if (put_scroll) begin
                        state_in = ST_SWEEP;
                     end
                  end
                  OP_READ: begin
                     rd_en      = read_hit;
                     read_ok_in = read_hit;
                  end
                  OP_CLEAR: begin
                     copy_in      = 1'b0;
                     fill_in      = blank_cell;
                     shown_row_in = '0;
                     shown_col_in = '0;
                     state_in     = ST_SWEEP;
                  end
                  default: begin
                     // unused operation: report the cursor only
                  end
               endcase
            end
         end
         ST_RESP: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_SWEEP;
         scan_ff       <= '0;
         copy_ff       <= 1'b0;
         resp_pend_ff  <= 1'b0;
         fill_ff       <= RESET_BLANK;
         wb_valid_ff   <= 1'b0;
         wb_copy_ff    <= 1'b0;
         row_ff        <= '0;
         col_ff        <= '0;
         shown_row_ff  <= '0;
         shown_col_ff  <= '0;
         read_ok_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         copy_ff       <= copy_in;
         resp_pend_ff  <= resp_pend_in;
         fill_ff       <= fill_in;
         wb_valid_ff   <= wb_valid_in;
         wb_copy_ff    <= wb_copy_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         shown_row_ff  <= shown_row_in;
         shown_col_ff  <= shown_col_in;
         read_ok_ff    <= read_ok_in;
         rsp_valid_ff  <= rsp_load || (rsp_valid_ff && rsp_stall);
      end
   end

   // payload
   always_ff @(posedge clock) begin
      wb_addr_ff <= wb_addr_in;
      wb_data_ff <= wb_data_in;
      if (rsp_load) begin
         rsp_row_ff  <= 5'(shown_row_ff);
         rsp_col_ff  <= 7'(shown_col_ff);
         rsp_data_ff <= read_ok_ff ? rd_data : 16'h0000;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_read_data     = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Register port
   // ---------------------------------------------------------------------
   logic csr_write;
   logic csr_hit;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_hit    = (csr_paddr[2] == REG_TEXT_COLOR);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {24'h000000, text_color_ff} : 32'h00000000;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_write && csr_hit) begin
         text_color_ff <= csr_pwdata[7:0];
      end
   end

endmodule

// ===== rtl/core/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg and text_console_writer_macros.svh.
`include "text_console_writer_macros.svh"

module tcw_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_cursor_row,
   input logic [6:0]  rsp_cursor_column,
   input logic        csr_pready
);

   // beats accepted but not yet delivered
   logic [1:0] open_ff;
   logic [1:0] open_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;

   always_comb begin
      open_in = open_ff;
      if (req_beat && !rsp_beat) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 2'd0;
      end else begin
         open_ff <= open_in;
      end
   end

   `TCW_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result beat dropped while stalled")
   `TCW_ASSERT(a_rsp_has_item, clock, reset, rsp_valid |-> (open_ff != 2'd0) && (open_ff != 2'd3), "result beat without an open item")
   `TCW_ASSERT(a_cursor_range, clock, reset, rsp_valid |-> (int'(rsp_cursor_column) < COLUMNS) && (int'(rsp_cursor_row) < ROWS) && csr_pready, "cursor off screen")
   `TCW_ASSERT_ALWAYS(a_clear_after_reset, clock, $past(reset) |-> req_stall && !rsp_valid, "beat taken during the clearing pass")

endmodule

bind text_console_writer tcw_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tcw_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_cursor_row    (rsp_cursor_row),
   .rsp_cursor_column (rsp_cursor_column),
   .csr_pready        (csr_pready)
);
